@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define TPD_ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: check failed");

// ante in a cycle implies cons in the same cycle
`define TPD_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// ante in a cycle implies cons in the next cycle
`define TPD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

@@ hdl/tpd_pkg.sv @@
`default_nettype none
package tpd_pkg;

   localparam int MAX_THREADS_DEF = 64;
   localparam int NUM_CPUS_DEF    = 8;

   localparam int REQ_W      = 2;
   localparam int CPU_W      = 4;   // internal cpu number, holds up to 15
   localparam int TCPU_W     = 4;
   localparam int CCPU_W     = 3;
   localparam int TID_W      = 6;
   localparam int ENTRY_W    = 32;
   localparam int CSR_W      = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CMDQ_DEPTH = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_INIT   = 2'd0,
      REQ_CREATE = 2'd1,
      REQ_DIE    = 2'd2,
      REQ_UNUSED = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_CPU  = 2'd1,
      ST_NO_ID    = 2'd2,
      ST_NOT_HEAD = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CPUS_IN_USE = 1'b0,
      CSR_BOOT_CPU    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_INIT,
      OP_CREATE,
      OP_DIE,
      OP_BAD,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                autosel;
      logic [CPU_W-1:0]    cpu;
      logic [CPU_W-1:0]    n;
      logic [CCPU_W-1:0]   caller_cpu;
      logic [TID_W-1:0]    caller_thread;
      logic [ENTRY_W-1:0]  entry;
   } cmd_type;

   typedef struct packed {
      status_type          status;
      logic [TID_W-1:0]    thread_id;
      logic [CCPU_W-1:0]   chosen_cpu;
      logic                wake_cpu;
      logic                next_valid;
      logic [ENTRY_W-1:0]  next_entry;
      logic                all_done;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage
`default_nettype wire

@@ hdl/thread_pool_dispatcher.sv @@
// Channel   Handshake               Direction  Carries
// req_*     req_valid / req_ready   in         one request word
// rsp_*     rsp_valid / rsp_ready   out        one result word per request
// csr_*     csr_wr_en               in         register write, no wait, no read-back
//
// From the back taking a word to its result being valid: init, bad cpu and
// unknown code go straight on; die, if the caller heads its queue, reads the
// link RAM and, if a next thread remains, the entry RAM; create skips busy
// slots (all MAX_THREADS if no id is free), after any pick among usable cpus.
// Reset is synchronous and clears control state at once; no clearing pass.
// A two-word command queue sits between front and back, so requests are
// taken, until it is full, while the back works or a result waits for rsp_ready.
`default_nettype none
`include "assert_macros.svh"
module thread_pool_dispatcher #(
   parameter int MAX_THREADS = tpd_pkg::MAX_THREADS_DEF,
   parameter int NUM_CPUS    = tpd_pkg::NUM_CPUS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [tpd_pkg::REQ_W-1:0]           req_req_type,
   input  wire logic signed [tpd_pkg::TCPU_W-1:0]   req_target_cpu,
   input  wire logic [tpd_pkg::CCPU_W-1:0]          req_caller_cpu,
   input  wire logic [tpd_pkg::TID_W-1:0]           req_caller_thread,
   input  wire logic [tpd_pkg::ENTRY_W-1:0]         req_entry_address,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_status,
   output logic [tpd_pkg::TID_W-1:0]                rsp_thread_id,
   output logic [tpd_pkg::CCPU_W-1:0]               rsp_chosen_cpu,
   output logic                                     rsp_wake_cpu,
   output logic                                     rsp_next_valid,
   output logic [tpd_pkg::ENTRY_W-1:0]              rsp_next_entry,
   output logic                                     rsp_all_done,
   input  wire logic                                csr_wr_en,
   input  wire logic [tpd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tpd_pkg::CSR_W-1:0]           csr_wdata
);
   tpd_pkg::q_stat_type  q_stat;
   tpd_pkg::cmd_type     push_cmd;
   tpd_pkg::cmd_type     pop_cmd;
   tpd_pkg::rsp_type     rsp;
   logic                 push;
   logic                 pop;
   logic                 rsp_ok;

   // front: config registers, request decode and cpu range checks
   tpd_front #(.NUM_CPUS(NUM_CPUS)) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_req_type      (req_req_type),
      .req_target_cpu    (req_target_cpu),
      .req_caller_cpu    (req_caller_cpu),
      .req_caller_thread (req_caller_thread),
      .req_entry_address (req_entry_address),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .q_stat            (q_stat),
      .push              (push),
      .cmd               (push_cmd)
   );

   // decoded commands wait here
   tpd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_stat   (q_stat)
   );

   // back: slot table, run queues, id scan, cpu pick, result register
   tpd_back #(.MAX_THREADS(MAX_THREADS), .NUM_CPUS(NUM_CPUS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .cmd       (pop_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_status     = rsp.status;
   assign rsp_thread_id  = rsp.thread_id;
   assign rsp_chosen_cpu = rsp.chosen_cpu;
   assign rsp_wake_cpu   = rsp.wake_cpu;
   assign rsp_next_valid = rsp.next_valid;
   assign rsp_next_entry = rsp.next_entry;
   assign rsp_all_done   = rsp.all_done;

   assign rsp_ok = (rsp_status == tpd_pkg::ST_OK);

   // an accepted word is queued in the next cycle
   `TPD_ASSERT_NEXT(a_push_lands, clock, reset, req_valid && req_ready, !q_stat.empty)
   // a new head is only reported by a successful die that left the queue non-empty
   `TPD_ASSERT_SAME(a_next_ok, clock, reset, rsp_valid && rsp_next_valid, rsp_ok && !rsp_all_done)
   // remote start only on a successful create
   `TPD_ASSERT_SAME(a_wake_ok, clock, reset, rsp_valid && rsp_wake_cpu, rsp_ok && !rsp_next_valid)
   // the back never pops an empty queue
   `TPD_ASSERT_ALWAYS(a_pop_nonempty, clock, reset, !(pop && q_stat.empty))
endmodule
`default_nettype wire

@@ hdl/tpd_ram.sv @@
`default_nettype none
module tpd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

@@ hdl/tpd_front.sv @@
`default_nettype none
module tpd_front #(
   parameter int NUM_CPUS = tpd_pkg::NUM_CPUS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [tpd_pkg::REQ_W-1:0]           req_req_type,
   input  wire logic signed [tpd_pkg::TCPU_W-1:0]   req_target_cpu,
   input  wire logic [tpd_pkg::CCPU_W-1:0]          req_caller_cpu,
   input  wire logic [tpd_pkg::TID_W-1:0]           req_caller_thread,
   input  wire logic [tpd_pkg::ENTRY_W-1:0]         req_entry_address,
   input  wire logic                                csr_wr_en,
   input  wire logic [tpd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tpd_pkg::CSR_W-1:0]           csr_wdata,
   input  wire tpd_pkg::q_stat_type                 q_stat,
   output logic                                     push,
   output tpd_pkg::cmd_type                         cmd
);
   localparam int CW = tpd_pkg::CPU_W;

   logic [CW-1:0]                  cpus_ff, cpus_in;
   logic [tpd_pkg::CCPU_W-1:0]     boot_ff, boot_in;
   logic [CW-1:0]                  n;
   logic [CW-1:0]                  tgt;
   logic [CW-1:0]                  ccpu;
   logic [CW-1:0]                  boot;

   always_comb begin
      cpus_in = cpus_ff;
      boot_in = boot_ff;
      if (csr_wr_en) begin
         case (tpd_pkg::csr_index_type'(csr_index))
            tpd_pkg::CSR_CPUS_IN_USE: cpus_in = csr_wdata;
            tpd_pkg::CSR_BOOT_CPU:    boot_in = csr_wdata[tpd_pkg::CCPU_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpus_ff <= CW'(1);
         boot_ff <= '0;
      end else begin
         cpus_ff <= cpus_in;
         boot_ff <= boot_in;
      end
   end

   // usable cpus = min(cpus_in_use, NUM_CPUS)
   assign n    = (32'(cpus_ff) > NUM_CPUS) ? CW'(NUM_CPUS) : cpus_ff;
   assign tgt  = {1'b0, req_target_cpu[tpd_pkg::TCPU_W-2:0]};
   assign ccpu = {1'b0, req_caller_cpu};
   assign boot = {1'b0, boot_ff};

   always_comb begin
      cmd               = '0;
      cmd.n             = n;
      cmd.caller_cpu    = req_caller_cpu;
      cmd.caller_thread = req_caller_thread;
      cmd.entry         = req_entry_address;
      cmd.autosel       = req_target_cpu[tpd_pkg::TCPU_W-1];
      case (tpd_pkg::req_code_type'(req_req_type))
         tpd_pkg::REQ_INIT: begin
            cmd.cpu = boot;
            cmd.op  = (boot >= n) ? tpd_pkg::OP_BAD : tpd_pkg::OP_INIT;
         end
         tpd_pkg::REQ_CREATE: begin
            cmd.cpu = tgt;
            if (n == '0 || (!cmd.autosel && tgt >= n)) begin
               cmd.op = tpd_pkg::OP_BAD;
            end else begin
               cmd.op = tpd_pkg::OP_CREATE;
            end
         end
         tpd_pkg::REQ_DIE: begin
            cmd.cpu = ccpu;
            cmd.op  = (ccpu >= n) ? tpd_pkg::OP_BAD : tpd_pkg::OP_DIE;
         end
         tpd_pkg::REQ_UNUSED: cmd.op = tpd_pkg::OP_NOP;
         default:             cmd.op = tpd_pkg::OP_NOP;
      endcase
   end

   assign req_ready = !q_stat.full;
   assign push      = req_valid && req_ready;
endmodule
`default_nettype wire

@@ hdl/tpd_fifo.sv @@
`default_nettype none
module tpd_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire tpd_pkg::cmd_type    push_cmd,
   input  wire logic                pop,
   output tpd_pkg::cmd_type         pop_cmd,
   output tpd_pkg::q_stat_type      q_stat
);
   localparam int DEPTH = tpd_pkg::CMDQ_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   tpd_pkg::cmd_type  entries_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     cnt_ff, cnt_in;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      bump = (32'(p) == DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd      = entries_ff[rd_ptr_ff];
   assign q_stat.full  = (32'(cnt_ff) == DEPTH);
   assign q_stat.empty = (cnt_ff == '0);
endmodule
`default_nettype wire

@@ hdl/tpd_back.sv @@
`default_nettype none
module tpd_back #(
   parameter int MAX_THREADS = tpd_pkg::MAX_THREADS_DEF,
   parameter int NUM_CPUS    = tpd_pkg::NUM_CPUS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tpd_pkg::q_stat_type  q_stat,
   input  wire tpd_pkg::cmd_type     cmd,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output tpd_pkg::rsp_type          rsp
);
   localparam int IDW = $clog2(MAX_THREADS);
   localparam int IW1 = IDW + 1;
   localparam int LW  = $clog2(MAX_THREADS + 1);
   localparam int CIW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int CW  = tpd_pkg::CPU_W;
   localparam int TW  = tpd_pkg::TID_W;
   localparam int EW  = tpd_pkg::ENTRY_W;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_PICK, S_SCAN, S_LINK, S_LINK2, S_DIE, S_DIE2, S_DIE3, S_EMIT
   } state_type;

   state_type               state_ff, state_in;
   tpd_pkg::cmd_type        cmd_ff, cmd_in;
   logic [MAX_THREADS-1:0]  busy_ff, busy_in;
   logic [IDW-1:0]          head_ff [NUM_CPUS];
   logic [IDW-1:0]          head_in [NUM_CPUS];
   logic [IDW-1:0]          tail_ff [NUM_CPUS];
   logic [IDW-1:0]          tail_in [NUM_CPUS];
   logic [LW-1:0]           count_ff [NUM_CPUS];
   logic [LW-1:0]           count_in [NUM_CPUS];
   logic [NUM_CPUS-1:0]     active_ff, active_in;
   logic [NUM_CPUS-1:0]     up_ff, up_in;
   logic [IDW-1:0]          ptr_ff, ptr_in;
   logic [LW-1:0]           live_ff, live_in;
   logic [CW-1:0]           cpu_ff, cpu_in;
   logic [CW-1:0]           pick_ff, pick_in;
   logic [CW-1:0]           best_ff, best_in;
   logic [LW-1:0]           low_ff, low_in;
   logic [IDW-1:0]          id_ff, id_in;
   logic [IDW-1:0]          scan_ff, scan_in;
   logic [IDW-1:0]          oldtail_ff, oldtail_in;
   tpd_pkg::rsp_type        res_ff, res_in;
   tpd_pkg::rsp_type        rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    ent_we;
   logic [IDW-1:0]          ent_waddr, ent_raddr;
   logic [EW-1:0]           ent_wdata, ent_rdata;
   logic                    nxt_we;
   logic [IDW-1:0]          nxt_waddr, nxt_raddr;
   logic [IDW-1:0]          nxt_wdata, nxt_rdata;

   logic [CIW-1:0]          ci;
   logic [CIW-1:0]          pi;
   logic                    take;
   logic [CW-1:0]           cand;
   logic [LW-1:0]           cnt_left;
   logic [LW-1:0]           live_after;

   function automatic logic [IDW-1:0] wrap_id(input logic [IDW-1:0] id);
      logic [IW1-1:0] nx;
      nx = {1'b0, id} + 1'b1;
      if (nx >= IW1'(MAX_THREADS)) begin
         wrap_id = '0;
      end else begin
         wrap_id = nx[IDW-1:0];
      end
   endfunction

   tpd_ram #(.WIDTH(EW), .DEPTH(MAX_THREADS)) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   tpd_ram #(.WIDTH(IDW), .DEPTH(MAX_THREADS)) u_next_ram (
      .clock (clock),
      .we    (nxt_we),
      .waddr (nxt_waddr),
      .wdata (nxt_wdata),
      .raddr (nxt_raddr),
      .rdata (nxt_rdata)
   );

   assign ci = CIW'(cpu_ff);
   assign pi = CIW'(pick_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      busy_in      = busy_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      active_in    = active_ff;
      up_in        = up_ff;
      ptr_in       = ptr_ff;
      live_in      = live_ff;
      cpu_in       = cpu_ff;
      pick_in      = pick_ff;
      best_in      = best_ff;
      low_in       = low_ff;
      id_in        = id_ff;
      scan_in      = scan_ff;
      oldtail_in   = oldtail_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop          = 1'b0;
      ent_we       = 1'b0;
      ent_waddr    = id_ff;
      ent_wdata    = cmd_ff.entry;
      ent_raddr    = '0;
      nxt_we       = 1'b0;
      nxt_waddr    = id_ff;
      nxt_wdata    = '0;
      nxt_raddr    = '0;
      take         = 1'b0;
      cand         = best_ff;
      cnt_left     = count_ff[ci] - 1'b1;
      live_after   = live_ff;

      case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               pop     = 1'b1;
               cmd_in  = cmd;
               res_in  = '0;
               cpu_in  = cmd.cpu;
               id_in   = ptr_ff;
               scan_in = '0;
               pick_in = '0;
               case (cmd.op)
                  tpd_pkg::OP_INIT:   state_in = S_INIT;
                  tpd_pkg::OP_CREATE: state_in = cmd.autosel ? S_PICK : S_SCAN;
                  tpd_pkg::OP_DIE:    state_in = S_DIE;
                  tpd_pkg::OP_BAD: begin
                     res_in.status = tpd_pkg::ST_BAD_CPU;
                     state_in      = S_EMIT;
                  end
                  default: state_in = S_EMIT;
               endcase
            end
         end

         S_INIT: begin
            busy_in    = '0;
            busy_in[0] = 1'b1;
            active_in  = '0;
            up_in      = '0;
            for (int c = 0; c < NUM_CPUS; c++) begin
               head_in[c]  = '0;
               tail_in[c]  = '0;
               count_in[c] = '0;
            end
            active_in[ci] = 1'b1;
            up_in[ci]     = 1'b1;
            count_in[ci]  = LW'(1);
            ptr_in        = wrap_id('0);
            live_in       = LW'(1);
            ent_we        = 1'b1;
            ent_waddr     = '0;
            ent_wdata     = '0;
            nxt_we        = 1'b1;
            nxt_waddr     = '0;
            nxt_wdata     = '0;
            res_in.chosen_cpu = cpu_ff[tpd_pkg::CCPU_W-1:0];
            state_in      = S_EMIT;
         end

         // one cpu a cycle: first inactive wins, else shortest queue, last on tie
         S_PICK: begin
            if (!active_ff[pi]) begin
               cpu_in   = pick_ff;
               state_in = S_SCAN;
            end else begin
               take = (pick_ff == '0) || (count_ff[pi] <= low_ff);
               if (take) begin
                  best_in = pick_ff;
                  low_in  = count_ff[pi];
                  cand    = pick_ff;
               end
               if (pick_ff == cmd_ff.n - CW'(1)) begin
                  cpu_in   = cand;
                  state_in = S_SCAN;
               end else begin
                  pick_in = pick_ff + 1'b1;
               end
            end
         end

         // one slot a cycle from the rotating pointer
         S_SCAN: begin
            if (!busy_ff[id_ff]) begin
               state_in = S_LINK;
            end else if (scan_ff == IDW'(MAX_THREADS - 1)) begin
               res_in.status = tpd_pkg::ST_NO_ID;
               state_in      = S_EMIT;
            end else begin
               id_in   = wrap_id(id_ff);
               scan_in = scan_ff + 1'b1;
            end
         end

         S_LINK: begin
            ent_we         = 1'b1;
            nxt_we         = 1'b1;
            busy_in[id_ff] = 1'b1;
            ptr_in         = wrap_id(id_ff);
            live_in        = live_ff + 1'b1;
            if (count_ff[ci] == '0) begin
               head_in[ci] = id_ff;
            end
            oldtail_in    = tail_ff[ci];
            tail_in[ci]   = id_ff;
            count_in[ci]  = count_ff[ci] + 1'b1;
            active_in[ci] = 1'b1;
            if (cpu_ff != {1'b0, cmd_ff.caller_cpu} && !up_ff[ci]) begin
               res_in.wake_cpu = 1'b1;
               up_in[ci]       = 1'b1;
            end
            res_in.thread_id  = TW'(id_ff);
            res_in.chosen_cpu = cpu_ff[tpd_pkg::CCPU_W-1:0];
            state_in = (count_ff[ci] == '0) ? S_EMIT : S_LINK2;
         end

         S_LINK2: begin
            nxt_we    = 1'b1;
            nxt_waddr = oldtail_ff;
            nxt_wdata = id_ff;
            state_in  = S_EMIT;
         end

         S_DIE: begin
            if (count_ff[ci] == '0 ||
                32'(head_ff[ci]) != 32'(cmd_ff.caller_thread)) begin
               res_in.status = tpd_pkg::ST_NOT_HEAD;
               state_in      = S_EMIT;
            end else begin
               id_in     = head_ff[ci];
               nxt_raddr = head_ff[ci];
               state_in  = S_DIE2;
            end
         end

         S_DIE2: begin
            count_in[ci] = cnt_left;
            if (busy_ff[id_ff]) begin
               busy_in[id_ff] = 1'b0;
               if (live_ff != '0) begin
                  live_after = live_ff - 1'b1;
               end
            end
            live_in = live_after;
            if (cnt_left != '0) begin
               head_in[ci]       = nxt_rdata;
               ent_raddr         = nxt_rdata;
               res_in.next_valid = 1'b1;
               res_in.thread_id  = TW'(nxt_rdata);
               state_in          = S_DIE3;
            end else begin
               tail_in[ci]     = head_ff[ci];
               res_in.all_done = (live_after == '0);
               state_in        = S_EMIT;
            end
         end

         S_DIE3: begin
            res_in.next_entry = ent_rdata;
            state_in          = S_EMIT;
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= '0;
         active_ff    <= '0;
         up_ff        <= '0;
         ptr_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CPUS; c++) begin
            head_ff[c]  <= '0;
            tail_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         up_ff        <= up_in;
         ptr_ff       <= ptr_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
         cpu_ff       <= cpu_in;
         pick_ff      <= pick_in;
         best_ff      <= best_in;
         low_ff       <= low_in;
         id_ff        <= id_in;
         scan_ff      <= scan_in;
         oldtail_ff   <= oldtail_in;
         res_ff       <= res_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
endmodule
`default_nettype wire
